### rtl/uvs_pkg.sv
// Shared widths, constants and types of the UV sphere vertex generator.
package uvs_pkg;

    localparam int CNT_W   = 11;
    localparam int IDX_W   = 11;
    localparam int POS_W   = 16;
    localparam int TEX_W   = 17;
    localparam int PHASE_W = 32;

    // Q30 unit and pi in Q2.30.
    localparam logic [30:0] Q30_ONE = 31'h4000_0000;
    localparam logic [31:0] PI_Q30  = 32'd3373259426;

    // Latency of the sine/cosine unit, from phase in to registered result.
    localparam int SC_LAT = 19;

    // Taylor divisors of the nested sine and cosine forms.
    localparam int SIN_STEPS = 4;
    localparam int COS_STEPS = 5;
    localparam int SIN_DIV [SIN_STEPS] = '{72, 42, 20, 6};
    localparam int COS_DIV [COS_STEPS] = '{90, 56, 30, 12, 2};

    // Configuration register indexes.
    localparam logic REG_STACK  = 1'b0;
    localparam logic REG_SECTOR = 1'b1;

    // Side data that rides along with the trig pipeline.
    typedef struct packed {
        logic             valid;
        logic             err;
        logic [TEX_W-1:0] tex_u;
        logic [TEX_W-1:0] tex_v;
    } t_side;

endpackage

### rtl/uvs_if.sv
// Valid/ready channel interfaces for grid points in and vertices out.
interface uvs_in_if;
    import uvs_pkg::*;
    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] stack_index;
    logic [IDX_W-1:0] sector_index;
    modport source(output valid, stack_index, sector_index, input ready);
    modport sink(input valid, stack_index, sector_index, output ready);
endinterface

interface uvs_out_if;
    import uvs_pkg::*;
    logic                    valid;
    logic                    ready;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
    logic        [TEX_W-1:0] tex_u;
    logic        [TEX_W-1:0] tex_v;
    logic                    index_error;
    modport source(output valid, pos_x, pos_y, pos_z, tex_u, tex_v, index_error,
                   input ready);
    modport sink(input valid, pos_x, pos_y, pos_z, tex_u, tex_v, index_error,
                 output ready);
endinterface

### rtl/uv_sphere_vertex_generator.sv
// Top level of the UV sphere vertex generator: config port, dividers, trig, output.
// One grid point enters and one vertex word leaves per cycle while the output is
// not stalled; a point passes 11 divider stages, 19 trig stages, one product
// stage and the output register. The whole pipeline advances together, so a
// stalled output word holds the pipeline and drops input ready. Counts are to be
// written through the APB port only while idle, which the block does not enforce.
// A zero count acts as one and a count above MAX_DIVISIONS is clamped.
module uv_sphere_vertex_generator #(
    parameter int MAX_DIVISIONS = 1024,
    parameter int FRACTION_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    uvs_in_if.sink      i_grid,
    uvs_out_if.source   o_vert,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import uvs_pkg::*;

    localparam int DIV_STAGES = 11;
    localparam int SEC_W      = IDX_W + 33;
    localparam int STK_W      = IDX_W + 32;
    localparam int TEXN_W     = IDX_W + FRACTION_BITS + 1;

    // Configuration registers.
    logic [CNT_W-1:0] r_stack_count;
    logic [CNT_W-1:0] r_sector_count;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stack_count  <= 11'd16;
            r_sector_count <= 11'd32;
        end else if (psel && penable && pwrite && pready) begin
            if (paddr[2] == REG_STACK) r_stack_count <= pwdata[CNT_W-1:0];
            else                       r_sector_count <= pwdata[CNT_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_SECTOR) ? 32'(r_sector_count) : 32'(r_stack_count);

    function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] v);
        if (v == '0)                      return 11'd1;
        else if (int'(v) > MAX_DIVISIONS) return 11'(MAX_DIVISIONS);
        else                              return v;
    endfunction

    logic [CNT_W-1:0] cnt_t;
    logic [CNT_W-1:0] cnt_s;
    assign cnt_t = eff_count(r_stack_count);
    assign cnt_s = eff_count(r_sector_count);

    // Pipeline enable: everything moves when the output register can take a word.
    logic r_out_valid;
    logic en;
    assign en = !r_out_valid || o_vert.ready;
    assign i_grid.ready = en;

    logic in_err;
    assign in_err = (i_grid.stack_index > cnt_t) || (i_grid.sector_index > cnt_s);

    logic [SEC_W-1:0]  sec_num, sec_quo;
    logic [STK_W-1:0]  stk_num, stk_quo;
    logic [TEXN_W-1:0] tu_num, tu_quo, tv_num, tv_quo;

    assign sec_num = (SEC_W'(i_grid.sector_index) << 32) + SEC_W'(cnt_s >> 1);
    assign stk_num = (STK_W'(i_grid.stack_index) << 31) + STK_W'(cnt_t >> 1);
    assign tu_num  = (TEXN_W'(i_grid.sector_index) << FRACTION_BITS) + TEXN_W'(cnt_s >> 1);
    assign tv_num  = (TEXN_W'(i_grid.stack_index) << FRACTION_BITS) + TEXN_W'(cnt_t >> 1);

    uvs_divider #(.NUM_W(SEC_W), .STAGES(DIV_STAGES)) u_div_sec (
        .i_clk(i_clk), .i_en(en), .i_num(sec_num), .i_den(cnt_s), .o_quo(sec_quo)
    );
    uvs_divider #(.NUM_W(STK_W), .STAGES(DIV_STAGES)) u_div_stk (
        .i_clk(i_clk), .i_en(en), .i_num(stk_num), .i_den(cnt_t), .o_quo(stk_quo)
    );
    uvs_divider #(.NUM_W(TEXN_W), .STAGES(DIV_STAGES)) u_div_tu (
        .i_clk(i_clk), .i_en(en), .i_num(tu_num), .i_den(cnt_s), .o_quo(tu_quo)
    );
    uvs_divider #(.NUM_W(TEXN_W), .STAGES(DIV_STAGES)) u_div_tv (
        .i_clk(i_clk), .i_en(en), .i_num(tv_num), .i_den(cnt_t), .o_quo(tv_quo)
    );

    logic [1:0] ve_div;
    uvs_delay #(.WIDTH(2), .DEPTH(DIV_STAGES)) u_vdly (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
        .i_data({i_grid.valid, in_err}), .o_data(ve_div)
    );

    // Phases in units of 2^-32 turn; the stack angle starts at a quarter turn.
    logic [PHASE_W-1:0] sec_ph;
    logic [PHASE_W-1:0] stk_ph;
    assign sec_ph = sec_quo[PHASE_W-1:0];
    assign stk_ph = 32'h4000_0000 - stk_quo[PHASE_W-1:0];

    logic signed [31:0] ss, cs, st, ct;
    uvs_sincos u_sc_sec (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_phase(sec_ph),
        .o_sin(ss), .o_cos(cs)
    );
    uvs_sincos u_sc_stk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_phase(stk_ph),
        .o_sin(st), .o_cos(ct)
    );

    t_side side_in, side_out;
    assign side_in.valid = ve_div[1];
    assign side_in.err   = ve_div[0];
    assign side_in.tex_u = tu_quo[TEX_W-1:0];
    assign side_in.tex_v = tv_quo[TEX_W-1:0];

    uvs_delay #(.WIDTH($bits(t_side)), .DEPTH(SC_LAT + 1)) u_sdly (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_data(side_in),
        .o_data(side_out)
    );

    // Product stage.
    logic signed [63:0] r_px;
    logic signed [63:0] r_pz;
    logic signed [31:0] r_py;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_px <= 64'(cs) * 64'(ct);
            r_pz <= 64'(ss) * 64'(ct);
            r_py <= st;
        end
    end

    // Round the magnitude half up, saturate, then put the sign back.
    function automatic logic [POS_W-1:0] to_q15(input logic signed [63:0] v,
                                                input int unsigned sh);
        logic [63:0] m;
        logic [15:0] m15;
        m = v[63] ? 64'(-v) : 64'(v);
        m = (m + (64'd1 << (sh - 1))) >> sh;
        m15 = (m > 64'd32767) ? 16'd32767 : m[15:0];
        return v[63] ? 16'(16'd0 - m15) : m15;
    endfunction

    logic [POS_W-1:0] r_pos_x, r_pos_y, r_pos_z;
    logic [TEX_W-1:0] r_tex_u, r_tex_v;
    logic             r_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= side_out.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_err <= side_out.err;
            if (side_out.err) begin
                r_pos_x <= '0;
                r_pos_y <= '0;
                r_pos_z <= '0;
                r_tex_u <= '0;
                r_tex_v <= '0;
            end else begin
                r_pos_x <= to_q15(r_px, 45);
                r_pos_y <= to_q15(64'(r_py), 15);
                r_pos_z <= to_q15(r_pz, 45);
                r_tex_u <= side_out.tex_u;
                r_tex_v <= side_out.tex_v;
            end
        end
    end

    assign o_vert.valid       = r_out_valid;
    assign o_vert.pos_x       = $signed(r_pos_x);
    assign o_vert.pos_y       = $signed(r_pos_y);
    assign o_vert.pos_z       = $signed(r_pos_z);
    assign o_vert.tex_u       = r_tex_u;
    assign o_vert.tex_v       = r_tex_v;
    assign o_vert.index_error = r_err;

    // A stalled output word must hold the whole pipeline.
    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_vert.valid && !o_vert.ready) |-> !i_grid.ready)
        else $error("input accepted while output word is stalled");

    // An index error word carries an all-zero payload.
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_vert.valid && o_vert.index_error) |->
        (o_vert.pos_x == 0 && o_vert.pos_y == 0 && o_vert.pos_z == 0 &&
         o_vert.tex_u == 0 && o_vert.tex_v == 0))
        else $error("index error word has nonzero payload");

    // Saturation keeps every coordinate inside +-32767.
    a_no_min_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_vert.valid |-> (o_vert.pos_x != 16'sh8000 && o_vert.pos_y != 16'sh8000 &&
                          o_vert.pos_z != 16'sh8000))
        else $error("coordinate outside saturation range");
endmodule

### rtl/uvs_delay.sv
// Enabled shift line that delays a word through DEPTH registers.
module uvs_delay #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic [WIDTH-1:0] i_data,
    output logic [WIDTH-1:0] o_data
);
    logic [WIDTH-1:0] r_tap [DEPTH];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DEPTH; k++) r_tap[k] <= '0;
        end else if (i_en) begin
            r_tap[0] <= i_data;
            for (int k = 1; k < DEPTH; k++) r_tap[k] <= r_tap[k-1];
        end
    end

    assign o_data = r_tap[DEPTH-1];
endmodule

### rtl/uvs_divider.sv
// Pipelined restoring divider of a wide numerator by an 11-bit divisor.
module uvs_divider #(
    parameter int NUM_W  = 44,
    parameter int STAGES = 6
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [NUM_W-1:0] i_num,
    input  logic [10:0]      i_den,
    output logic [NUM_W-1:0] o_quo
);
    localparam int SPS = (NUM_W + STAGES - 1) / STAGES;
    localparam int P   = SPS * STAGES;

    // Numerator bits shift out at the top while quotient bits shift in below.
    logic [P-1:0] r_num [STAGES];
    logic [10:0]  r_rem [STAGES];

    for (genvar s = 0; s < STAGES; s++) begin : g_stage
        logic [P-1:0] n_num;
        logic [10:0]  n_rem;

        always_comb begin
            logic [11:0] trial;
            if (s == 0) begin
                n_num = P'(i_num);
                n_rem = '0;
            end else begin
                n_num = r_num[(s == 0) ? 0 : s-1];
                n_rem = r_rem[(s == 0) ? 0 : s-1];
            end
            for (int k = 0; k < SPS; k++) begin
                trial = {n_rem, n_num[P-1]};
                n_num = {n_num[P-2:0], 1'b0};
                if (trial >= {1'b0, i_den}) begin
                    n_rem    = 11'(trial - {1'b0, i_den});
                    n_num[0] = 1'b1;
                end else begin
                    n_rem = trial[10:0];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_num[s] <= n_num;
                r_rem[s] <= n_rem;
            end
        end
    end

    assign o_quo = r_num[STAGES-1][NUM_W-1:0];
endmodule

### rtl/uvs_poly_step.sv
// One nested Taylor step, t' = 1 - ((x2 * t) >> 30) / DIVISOR, over three stages.
module uvs_poly_step #(
    parameter int DIVISOR = 72
) (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [29:0] i_x2,
    input  logic [30:0] i_t,
    output logic [29:0] o_x2,
    output logic [30:0] o_t
);
    import uvs_pkg::*;

    // Exact reciprocal for 30-bit dividends.
    localparam int L = $clog2(DIVISOR);
    localparam longint unsigned RECIP_L =
        ((64'd1 << (30 + L)) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
    localparam logic [30:0] RECIP = 31'(RECIP_L);

    logic [29:0] r_v;
    logic [29:0] r_x2_a;
    logic [60:0] r_m;
    logic [29:0] r_x2_b;
    logic [30:0] r_t;
    logic [29:0] r_x2_c;
    logic [60:0] prod;

    assign prod = 61'(i_x2) * 61'(i_t);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_v    <= prod[59:30];
            r_x2_a <= i_x2;
            r_m    <= 61'(r_v) * 61'(RECIP);
            r_x2_b <= r_x2_a;
            r_t    <= Q30_ONE - 31'(r_m >> (30 + L));
            r_x2_c <= r_x2_b;
        end
    end

    assign o_x2 = r_x2_c;
    assign o_t  = r_t;
endmodule

### rtl/uvs_sincos.sv
// Sine and cosine of a 32-bit turn phase in signed Q30, fully pipelined.
module uvs_sincos (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic [uvs_pkg::PHASE_W-1:0]  i_phase,
    output logic signed [31:0]           o_sin,
    output logic signed [31:0]           o_cos
);
    import uvs_pkg::*;

    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;

    logic [31:0] qsum;
    logic [1:0]  quad;
    logic [31:0] d;
    logic [31:0] dneg;

    logic [1:0]  r1_q, r2_q, r3_q;
    logic        r1_neg, r2_neg, r3_neg;
    logic [29:0] r1_mag;
    logic [29:0] r2_x, r3_x;
    logic [29:0] r3_x2;
    logic [61:0] xpi;
    logic [59:0] xsq;

    assign qsum = i_phase + 32'h2000_0000;
    assign quad = qsum[31:30];
    assign d    = i_phase - {quad, 30'd0};
    assign dneg = 32'd0 - d;
    assign xpi  = 62'(r1_mag) * 62'(PI_Q30);
    assign xsq  = 60'(r2_x) * 60'(r2_x);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_q   <= quad;
            r1_neg <= d[31];
            r1_mag <= d[31] ? dneg[29:0] : d[29:0];
            r2_q   <= r1_q;
            r2_neg <= r1_neg;
            r2_x   <= xpi[60:31];
            r3_q   <= r2_q;
            r3_neg <= r2_neg;
            r3_x   <= r2_x;
            r3_x2  <= xsq[59:30];
        end
    end

    // Sine chain.
    logic [29:0] sx2 [SIN_STEPS+1];
    logic [30:0] st  [SIN_STEPS+1];
    assign sx2[0] = r3_x2;
    assign st[0]  = Q30_ONE;
    for (genvar g = 0; g < SIN_STEPS; g++) begin : g_sin
        uvs_poly_step #(.DIVISOR(SIN_DIV[g])) u_step (
            .i_clk(i_clk), .i_en(i_en), .i_x2(sx2[g]), .i_t(st[g]),
            .o_x2(sx2[g+1]), .o_t(st[g+1])
        );
    end

    // Cosine chain.
    logic [29:0] cx2 [COS_STEPS+1];
    logic [30:0] ct  [COS_STEPS+1];
    assign cx2[0] = r3_x2;
    assign ct[0]  = Q30_ONE;
    for (genvar g = 0; g < COS_STEPS; g++) begin : g_cos
        uvs_poly_step #(.DIVISOR(COS_DIV[g])) u_step (
            .i_clk(i_clk), .i_en(i_en), .i_x2(cx2[g]), .i_t(ct[g]),
            .o_x2(cx2[g+1]), .o_t(ct[g+1])
        );
    end

    // The angle itself waits for the sine chain, for the closing multiply.
    logic [29:0] x_d;
    uvs_delay #(.WIDTH(30), .DEPTH(3 * SIN_STEPS)) u_xdly (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(i_en), .i_data(r3_x), .o_data(x_d)
    );

    logic [60:0] sprod;
    logic [30:0] r_sin_mag;
    logic [30:0] sin_al;
    assign sprod = 61'(x_d) * 61'(st[SIN_STEPS]);

    always_ff @(posedge i_clk) begin
        if (i_en) r_sin_mag <= sprod[60:30];
    end

    uvs_delay #(.WIDTH(31), .DEPTH(3 * (COS_STEPS - SIN_STEPS) - 1)) u_sdly (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(i_en), .i_data(r_sin_mag),
        .o_data(sin_al)
    );

    logic [2:0] qn_al;
    uvs_delay #(.WIDTH(3), .DEPTH(3 * COS_STEPS)) u_qdly (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(i_en), .i_data({r3_q, r3_neg}),
        .o_data(qn_al)
    );

    logic signed [31:0] sr;
    logic signed [31:0] cr;
    logic signed [31:0] r_s;
    logic signed [31:0] r_c;
    assign sr = qn_al[0] ? -$signed({1'b0, sin_al}) : $signed({1'b0, sin_al});
    assign cr = $signed({1'b0, ct[COS_STEPS]});

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            case (qn_al[2:1])
                QUAD_0: begin
                    r_s <= sr;
                    r_c <= cr;
                end
                QUAD_1: begin
                    r_s <= cr;
                    r_c <= -sr;
                end
                QUAD_2: begin
                    r_s <= -sr;
                    r_c <= -cr;
                end
                default: begin
                    r_s <= -cr;
                    r_c <= sr;
                end
            endcase
        end
    end

    assign o_sin = r_s;
    assign o_cos = r_c;
endmodule
